[rtl/core/hbls_pkg.sv]
// Package for the hash bucket list store: state encoding, command and status codes,
// and default sizes. No dependencies.
package hbls_pkg;

  localparam int unsigned DefEntries  = 16;
  localparam int unsigned DefKeyBytes = 32;
  localparam int unsigned InKeyBytes  = 32;

  localparam logic [1:0] CMD_INSERT   = 2'd0;
  localparam logic [1:0] CMD_DELETE   = 2'd1;
  localparam logic [1:0] CMD_FIND     = 2'd2;
  localparam logic [1:0] CMD_RESERVED = 2'd3;

  localparam logic [1:0] STS_OK       = 2'd0;
  localparam logic [1:0] STS_NOTFOUND = 2'd1;
  localparam logic [1:0] STS_FULL     = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INS_RD,
    ST_INS_LINK,
    ST_INS_W_SLOT,
    ST_INS_W_HEAD,
    ST_WALK,
    ST_DEL_W_PREV,
    ST_DEL_W_NEXT,
    ST_DEL_W_SLOT,
    ST_DONE
  } hbls_state_e;

endpackage

[rtl/core/hbls_ram.sv]
// Single-port-write, single-port-read slot memory with a per-bit write mask.
// Read data is registered. Depends on nothing.
module hbls_ram #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 8,
  parameter int unsigned AW    = 4
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wmask_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      for (int i = 0; i < WIDTH; i++) begin
        if (wmask_i[i]) begin
          mem[waddr_i][i] <= wdata_i[i];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/hbls_key_form.sv]
// Brings an incoming key into stored form: bytes from the first zero byte on read as zero.
// Depends on hbls_pkg.
module hbls_key_form
  import hbls_pkg::*;
#(
  parameter int unsigned KEY_BYTES = DefKeyBytes
) (
  input  logic [63:0]            key_word0_i,
  input  logic [63:0]            key_word1_i,
  input  logic [63:0]            key_word2_i,
  input  logic [63:0]            key_word3_i,
  output logic [KEY_BYTES*8-1:0] key_o
);

  logic [InKeyBytes*8-1:0] in_flat;

  assign in_flat = {key_word3_i, key_word2_i, key_word1_i, key_word0_i};

  always_comb begin
    logic alive;
    alive = 1'b1;
    key_o = '0;
    for (int b = 0; b < KEY_BYTES; b++) begin
      alive = alive & (in_flat[b*8 +: 8] != 8'd0);
      key_o[b*8 +: 8] = alive ? in_flat[b*8 +: 8] : 8'd0;
    end
  end

endmodule

[rtl/core/hash_bucket_list_store_unit.sv]
// Top level of the hash bucket list store: sequencer, slot memory and result register.
// Depends on hbls_pkg, hbls_ram and hbls_key_form.

// One hash bucket kept as a circular doubly linked list in a slot memory of ENTRIES rows,
// each row holding key, hash, next and prev link; unused slots form a free list. One item is
// worked at a time and gives one result. Insert into an empty bucket writes the slot at once,
// else links the tail to it, writes it and sets the head prev link; a full bucket, a reserved
// command or a find or delete in an empty bucket goes straight to the result. Find and delete
// walk the list from the head one slot per cycle through the memory read port; delete then
// relinks the neighbours and frees the slot. The item port stalls while an item is at work or
// its result waits for the output register, where a result waits while the next item is taken.
// No clearing pass follows reset: never-used slots are tracked by a fill count.
module hash_bucket_list_store_unit
  import hbls_pkg::*;
#(
  parameter int unsigned ENTRIES   = DefEntries,
  parameter int unsigned KEY_BYTES = DefKeyBytes
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  cmd_i,
  input  logic [31:0] hash_value_i,
  input  logic [63:0] key_word0_i,
  input  logic [63:0] key_word1_i,
  input  logic [63:0] key_word2_i,
  input  logic [63:0] key_word3_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [3:0]  slot_index_o,
  output logic [4:0]  entry_count_o
);

  localparam int unsigned SW       = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned LW       = $clog2(ENTRIES + 1);
  localparam int unsigned KW       = KEY_BYTES * 8;
  localparam int unsigned HASH_LSB = KW;
  localparam int unsigned NEXT_LSB = KW + 32;
  localparam int unsigned PREV_LSB = KW + 32 + LW;
  localparam int unsigned RW       = KW + 32 + 2 * LW;
  localparam logic [LW-1:0] EntriesL = LW'(ENTRIES);

  function automatic logic [SW-1:0] fix_slot(input logic [LW-1:0] s);
    logic [SW-1:0] r;
    r = (s < EntriesL) ? s[SW-1:0] : '0;
    return r;
  endfunction

  hbls_state_e state_q, state_d;

  logic [LW-1:0] head_dummy;
  logic [SW-1:0] head_q, head_d;
  logic [LW-1:0] free_q, free_d;
  logic [LW-1:0] live_q, live_d;
  logic [LW-1:0] fresh_q, fresh_d;
  logic          out_valid_q, out_valid_d;

  logic [1:0]    cmd_q, cmd_d;
  logic [31:0]   hash_q, hash_d;
  logic [KW-1:0] key_q, key_d;
  logic [SW-1:0] slot_q, slot_d;
  logic [SW-1:0] cur_q, cur_d;
  logic [LW-1:0] n_q, n_d;
  logic [SW-1:0] tail_q, tail_d;
  logic [SW-1:0] p_q, p_d;
  logic [SW-1:0] nx_q, nx_d;
  logic [1:0]    res_status_q, res_status_d;
  logic [SW-1:0] res_slot_q, res_slot_d;
  logic [1:0]    out_status_q, out_status_d;
  logic [3:0]    out_slot_q, out_slot_d;
  logic [4:0]    out_count_q, out_count_d;

  logic [KW-1:0] key_formed;
  logic          in_accept;
  logic          out_load;

  logic          ram_we;
  logic [SW-1:0] ram_waddr;
  logic [RW-1:0] ram_wmask;
  logic [RW-1:0] ram_wdata;
  logic [SW-1:0] ram_raddr;
  logic [RW-1:0] ram_rdata;

  logic [LW-1:0] rd_next;
  logic [LW-1:0] rd_prev;
  logic [31:0]   rd_hash;
  logic [KW-1:0] rd_key;
  logic          hit;
  logic          more;
  logic [LW-1:0] slot_l;
  logic          slot_fresh;
  logic [LW-1:0] next_free;

  hbls_key_form #(
    .KEY_BYTES(KEY_BYTES)
  ) u_key_form (
    .key_word0_i(key_word0_i),
    .key_word1_i(key_word1_i),
    .key_word2_i(key_word2_i),
    .key_word3_i(key_word3_i),
    .key_o      (key_formed)
  );

  hbls_ram #(
    .DEPTH(ENTRIES),
    .WIDTH(RW),
    .AW   (SW)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wmask_i(ram_wmask),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign head_dummy = LW'(head_q);

  assign rd_key  = ram_rdata[KW-1:0];
  assign rd_hash = ram_rdata[HASH_LSB +: 32];
  assign rd_next = ram_rdata[NEXT_LSB +: LW];
  assign rd_prev = ram_rdata[PREV_LSB +: LW];

  assign hit  = (rd_hash == hash_q) && (rd_key[7:0] != 8'd0) && (rd_key == key_q);
  assign more = ({1'b0, n_q} + (LW+1)'(1)) < {1'b0, live_q};

  // Slots at or above the fill count were never written; their free successor is slot + 1.
  assign slot_l     = LW'(slot_q);
  assign slot_fresh = slot_l >= fresh_q;
  assign next_free  = slot_fresh ? (slot_l + LW'(1)) : rd_next;

  assign in_accept  = in_valid_i && (state_q == ST_IDLE);
  assign in_stall_o = (state_q != ST_IDLE);
  assign out_load   = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          case (cmd_i)
            CMD_INSERT: state_d = (live_q == EntriesL) ? ST_DONE : ST_INS_RD;
            CMD_DELETE,
            CMD_FIND:   state_d = (live_q == '0) ? ST_DONE : ST_WALK;
            default:    state_d = ST_DONE;
          endcase
        end
      end
      ST_INS_RD:     state_d = (live_q == '0) ? ST_DONE : ST_INS_LINK;
      ST_INS_LINK:   state_d = ST_INS_W_SLOT;
      ST_INS_W_SLOT: state_d = ST_INS_W_HEAD;
      ST_INS_W_HEAD: state_d = ST_DONE;
      ST_WALK: begin
        if (hit) begin
          state_d = (cmd_q == CMD_DELETE) ? ST_DEL_W_PREV : ST_DONE;
        end else if (!more) begin
          state_d = ST_DONE;
        end
      end
      ST_DEL_W_PREV: state_d = ST_DEL_W_NEXT;
      ST_DEL_W_NEXT: state_d = ST_DEL_W_SLOT;
      ST_DEL_W_SLOT: state_d = ST_DONE;
      ST_DONE:       state_d = out_load ? ST_IDLE : ST_DONE;
      default:       state_d = ST_IDLE;
    endcase
  end

  // Memory accesses.
  always_comb begin
    ram_raddr = fix_slot(head_dummy);
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wmask = '0;
    ram_wdata = '0;
    case (state_q)
      ST_IDLE: begin
        ram_raddr = (cmd_i == CMD_INSERT) ? fix_slot(free_q) : fix_slot(head_dummy);
      end
      ST_INS_RD: begin
        if (live_q == '0) begin
          ram_we    = 1'b1;
          ram_waddr = slot_q;
          ram_wmask = '1;
          ram_wdata = {slot_l, slot_l, hash_q, key_q};
        end
      end
      ST_INS_LINK: begin
        ram_we    = 1'b1;
        ram_waddr = fix_slot(rd_prev);
        ram_wmask[NEXT_LSB +: LW] = '1;
        ram_wdata[NEXT_LSB +: LW] = slot_l;
      end
      ST_INS_W_SLOT: begin
        ram_we    = 1'b1;
        ram_waddr = slot_q;
        ram_wmask = '1;
        ram_wdata = {LW'(tail_q), LW'(fix_slot(head_dummy)), hash_q, key_q};
      end
      ST_INS_W_HEAD: begin
        ram_we    = 1'b1;
        ram_waddr = fix_slot(head_dummy);
        ram_wmask[PREV_LSB +: LW] = '1;
        ram_wdata[PREV_LSB +: LW] = slot_l;
      end
      ST_WALK: begin
        ram_raddr = fix_slot(rd_next);
      end
      ST_DEL_W_PREV: begin
        ram_we    = 1'b1;
        ram_waddr = p_q;
        ram_wmask[NEXT_LSB +: LW] = '1;
        ram_wdata[NEXT_LSB +: LW] = LW'(nx_q);
      end
      ST_DEL_W_NEXT: begin
        ram_we    = 1'b1;
        ram_waddr = nx_q;
        ram_wmask[PREV_LSB +: LW] = '1;
        ram_wdata[PREV_LSB +: LW] = LW'(p_q);
      end
      ST_DEL_W_SLOT: begin
        ram_we    = 1'b1;
        ram_waddr = slot_q;
        ram_wmask[NEXT_LSB +: LW] = '1;
        ram_wmask[PREV_LSB +: LW] = '1;
        ram_wdata[NEXT_LSB +: LW] = free_q;
      end
      default: begin
      end
    endcase
  end

  // Register updates.
  always_comb begin
    head_d       = head_q;
    free_d       = free_q;
    live_d       = live_q;
    fresh_d      = fresh_q;
    cmd_d        = cmd_q;
    hash_d       = hash_q;
    key_d        = key_q;
    slot_d       = slot_q;
    cur_d        = cur_q;
    n_d          = n_q;
    tail_d       = tail_q;
    p_d          = p_q;
    nx_d         = nx_q;
    res_status_d = res_status_q;
    res_slot_d   = res_slot_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_status_d = out_status_q;
    out_slot_d   = out_slot_q;
    out_count_d  = out_count_q;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          cmd_d        = cmd_i;
          hash_d       = hash_value_i;
          key_d        = key_formed;
          slot_d       = fix_slot(free_q);
          cur_d        = head_q;
          n_d          = '0;
          res_slot_d   = '0;
          res_status_d = STS_NOTFOUND;
          if (cmd_i == CMD_INSERT && live_q == EntriesL) begin
            res_status_d = STS_FULL;
          end
        end
      end
      ST_INS_RD: begin
        free_d = next_free;
        if (slot_fresh) begin
          fresh_d = fresh_q + LW'(1);
        end
        if (live_q == '0) begin
          head_d       = slot_q;
          live_d       = live_q + LW'(1);
          res_status_d = STS_OK;
          res_slot_d   = slot_q;
        end
      end
      ST_INS_LINK: begin
        tail_d = fix_slot(rd_prev);
      end
      ST_INS_W_HEAD: begin
        live_d       = live_q + LW'(1);
        res_status_d = STS_OK;
        res_slot_d   = slot_q;
      end
      ST_WALK: begin
        if (hit) begin
          res_status_d = STS_OK;
          res_slot_d   = cur_q;
          slot_d       = cur_q;
          p_d          = fix_slot(rd_prev);
          nx_d         = fix_slot(rd_next);
          if (cmd_q == CMD_DELETE && cur_q == head_q) begin
            head_d = fix_slot(rd_next);
          end
        end else if (more) begin
          cur_d = fix_slot(rd_next);
          n_d   = n_q + LW'(1);
        end
      end
      ST_DEL_W_SLOT: begin
        free_d = slot_l;
        live_d = live_q - LW'(1);
      end
      ST_DONE: begin
        if (out_load) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_slot_d   = 4'(res_slot_q);
          out_count_d  = 5'(live_q);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      free_q      <= '0;
      live_q      <= '0;
      fresh_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      free_q      <= free_d;
      live_q      <= live_d;
      fresh_q     <= fresh_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    hash_q       <= hash_d;
    key_q        <= key_d;
    slot_q       <= slot_d;
    cur_q        <= cur_d;
    n_q          <= n_d;
    tail_q       <= tail_d;
    p_q          <= p_d;
    nx_q         <= nx_d;
    res_status_q <= res_status_d;
    res_slot_q   <= res_slot_d;
    out_status_q <= out_status_d;
    out_slot_q   <= out_slot_d;
    out_count_q  <= out_count_d;
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign slot_index_o  = out_slot_q;
  assign entry_count_o = out_count_q;

`ifndef SYNTHESIS
  a_live_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (live_q <= EntriesL) && (fresh_q <= EntriesL))
    else $error("live or fill count beyond ENTRIES");

  a_miss_slot_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != STS_OK) |-> (slot_index_o == 4'd0))
    else $error("slot index not zero on a miss or full result");

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (state_q != ST_IDLE))
    else $error("accepted item did not start work");

  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q != ST_IDLE && state_q != ST_DONE && state_q != ST_WALK))
    else $error("memory written outside a write step");
`endif

endmodule
